// ===== sv/gcf_pkg.sv =====
// ----------------------------------------------------------------------------
// gcf_pkg
// constants, types and helper functions of the g-code line framer
// ----------------------------------------------------------------------------
package gcf_pkg;

  localparam int unsigned LINE_CAP  = 40;
  localparam int unsigned KEPT_W    = $clog2(LINE_CAP + 1);
  localparam int unsigned ADDR_W    = $clog2(LINE_CAP);
  localparam int unsigned NUM_DIGS  = 10;
  localparam int unsigned DIG_IDX_W = $clog2(NUM_DIGS);

  typedef logic [7:0]                    byte_t;
  typedef logic [KEPT_W-1:0]             kept_t;
  typedef logic [ADDR_W-1:0]             addr_t;
  typedef logic [DIG_IDX_W-1:0]          dig_idx_t;
  typedef logic [NUM_DIGS-1:0][3:0]      bcd_t;
  typedef logic [2:0][3:0]               ck_dec_t;

  localparam kept_t CAP_K = kept_t'(LINE_CAP);

  localparam byte_t CH_SEMI  = 8'd59;
  localparam byte_t CH_SPACE = 8'd32;
  localparam byte_t CH_N     = 8'd78;
  localparam byte_t CH_STAR  = 8'd42;
  localparam byte_t CH_LF    = 8'd10;
  localparam byte_t CH_CR    = 8'd13;
  localparam byte_t CH_ZERO  = 8'd48;

  // line number just before the 32-bit wrap, in bcd
  localparam bcd_t LNUM_WRAP = 40'h4294967295;

  function automatic bcd_t bcd_inc(input bcd_t v);
    bcd_t res;
    logic carry;
    res   = v;
    carry = 1'b1;
    for (int i = 0; i < NUM_DIGS; i++) begin
      if (carry) begin
        if (res[i] == 4'd9) begin
          res[i] = 4'd0;
        end else begin
          res[i] = res[i] + 4'd1;
          carry  = 1'b0;
        end
      end
    end
    return res;
  endfunction

  // index of the most significant non-zero digit, zero for the value zero
  function automatic dig_idx_t bcd_top(input bcd_t v);
    dig_idx_t idx;
    idx = '0;
    for (int i = 0; i < NUM_DIGS; i++) begin
      if (v[i] != 4'd0) begin
        idx = dig_idx_t'(i);
      end
    end
    return idx;
  endfunction

  function automatic ck_dec_t ck_digits(input byte_t s);
    ck_dec_t   d;
    logic [1:0]  h;
    byte_t       r;
    logic [15:0] prod;
    logic [3:0]  t;
    byte_t       o;
    if (s >= 8'd200) begin
      h = 2'd2;
      r = s - 8'd200;
    end else if (s >= 8'd100) begin
      h = 2'd1;
      r = s - 8'd100;
    end else begin
      h = 2'd0;
      r = s;
    end
    prod = {8'b0, r} * 16'd205;
    t    = prod[14:11];
    o    = r - ({4'b0, t} * 8'd10);
    d[2] = {2'b0, h};
    d[1] = t;
    d[0] = o[3:0];
    return d;
  endfunction

  function automatic logic [1:0] ck_top(input byte_t s);
    logic [1:0] idx;
    if (s >= 8'd100) begin
      idx = 2'd2;
    end else if (s >= 8'd10) begin
      idx = 2'd1;
    end else begin
      idx = 2'd0;
    end
    return idx;
  endfunction

endpackage

// ===== sv/gcf_if.sv =====
// ----------------------------------------------------------------------------
// gcf_if
// valid/ready channels of the g-code line framer
// ----------------------------------------------------------------------------
interface gcf_in_if;
  logic           valid;
  logic           ready;
  gcf_pkg::byte_t byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface gcf_out_if;
  logic           valid;
  logic           ready;
  gcf_pkg::byte_t out_byte;
  logic           last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ===== sv/gcode_line_number_checksum_framer.sv =====
// ----------------------------------------------------------------------------
// gcode_line_number_checksum_framer
// frames g-code text into numbered lines with an xor checksum
// ----------------------------------------------------------------------------
// Raw text is taken one byte per request while idle: comment bytes are
// dropped and kept bytes go into a 40-entry line memory. A line feed, carriage
// return or overflow starts framing, during which no input is taken. The framer
// sends one header or trailer byte per cycle while the output is not stalled,
// and each text byte is fetched through the memory's single read port with a
// registered read before it is sent, so text bytes do not go out back to back.
// A line that trims to nothing produces no output. A result waits in an output
// register while the framer moves on.
module gcode_line_number_checksum_framer (
  input  logic          clk,
  input  logic          rst_n,
  gcf_in_if.sink        in_req,
  gcf_out_if.source     out_res
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_HEAD = 9'b000000010,
    S_DIG  = 9'b000000100,
    S_SP   = 9'b000001000,
    S_RD   = 9'b000010000,
    S_TXT  = 9'b000100000,
    S_STAR = 9'b001000000,
    S_CK   = 9'b010000000,
    S_LF   = 9'b100000000
  } state_t;

  state_t                state_r, state_nxt;
  gcf_pkg::kept_t        kept_r, kept_nxt;
  gcf_pkg::kept_t        trim_r, trim_nxt;
  gcf_pkg::kept_t        len_r, len_nxt;
  logic                  cmt_r, cmt_nxt;
  gcf_pkg::bcd_t         lnum_r, lnum_nxt;
  gcf_pkg::dig_idx_t     dig_i_r, dig_i_nxt;
  gcf_pkg::addr_t        txt_i_r, txt_i_nxt;
  gcf_pkg::byte_t        sum_r, sum_nxt;
  gcf_pkg::ck_dec_t      ck_r, ck_nxt;
  logic [1:0]            ck_i_r, ck_i_nxt;
  logic                  ov_r, ov_nxt;
  gcf_pkg::byte_t        ob_r, ob_nxt;
  logic                  ol_r, ol_nxt;

  gcf_pkg::byte_t        mem [gcf_pkg::LINE_CAP];
  logic                  wr_en;
  logic                  rd_en;
  gcf_pkg::byte_t        rd_data_r;

  logic                  in_acc;
  logic                  slot_free;
  logic                  line_end;
  logic                  full;
  gcf_pkg::byte_t        b;
  gcf_pkg::byte_t        dig_byte;
  gcf_pkg::byte_t        ck_byte;

  assign in_req.ready     = (state_r == S_IDLE);
  assign in_acc           = in_req.valid && in_req.ready;
  assign b                = in_req.byte_in;
  assign line_end         = (b == gcf_pkg::CH_LF) || (b == gcf_pkg::CH_CR);
  assign full             = (kept_r == gcf_pkg::CAP_K);
  assign slot_free        = !ov_r || out_res.ready;
  assign dig_byte         = gcf_pkg::CH_ZERO + {4'b0, lnum_r[dig_i_r]};
  assign ck_byte          = gcf_pkg::CH_ZERO + {4'b0, ck_r[ck_i_r]};

  assign out_res.valid    = ov_r;
  assign out_res.out_byte = ob_r;
  assign out_res.last     = ol_r;

  // line memory, written only while idle and read only while framing
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[kept_r[gcf_pkg::ADDR_W-1:0]] <= b;
    end
    if (rd_en) begin
      rd_data_r <= mem[txt_i_r];
    end
  end

  always_comb begin
    state_nxt = state_r;
    kept_nxt  = kept_r;
    trim_nxt  = trim_r;
    len_nxt   = len_r;
    cmt_nxt   = cmt_r;
    lnum_nxt  = lnum_r;
    dig_i_nxt = dig_i_r;
    txt_i_nxt = txt_i_r;
    sum_nxt   = sum_r;
    ck_nxt    = ck_r;
    ck_i_nxt  = ck_i_r;
    ov_nxt    = ov_r && !out_res.ready;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (line_end || full) begin
            cmt_nxt  = !line_end;
            kept_nxt = '0;
            trim_nxt = '0;
            if (trim_r != '0) begin
              len_nxt   = trim_r;
              sum_nxt   = '0;
              state_nxt = S_HEAD;
            end
          end else begin
            if (b == gcf_pkg::CH_SEMI) begin
              cmt_nxt = 1'b1;
            end
            if (!cmt_r && (b != gcf_pkg::CH_SEMI)) begin
              wr_en    = 1'b1;
              kept_nxt = kept_r + gcf_pkg::kept_t'(1);
              if (b != gcf_pkg::CH_SPACE) begin
                trim_nxt = kept_r + gcf_pkg::kept_t'(1);
              end
            end
          end
        end
      end
      S_HEAD: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = gcf_pkg::CH_N;
          ol_nxt    = 1'b0;
          sum_nxt   = sum_r ^ gcf_pkg::CH_N;
          dig_i_nxt = gcf_pkg::bcd_top(lnum_r);
          state_nxt = S_DIG;
        end
      end
      S_DIG: begin
        if (slot_free) begin
          ov_nxt  = 1'b1;
          ob_nxt  = dig_byte;
          ol_nxt  = 1'b0;
          sum_nxt = sum_r ^ dig_byte;
          if (dig_i_r == '0) begin
            state_nxt = S_SP;
          end else begin
            dig_i_nxt = dig_i_r - gcf_pkg::dig_idx_t'(1);
          end
        end
      end
      S_SP: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = gcf_pkg::CH_SPACE;
          ol_nxt    = 1'b0;
          sum_nxt   = sum_r ^ gcf_pkg::CH_SPACE;
          txt_i_nxt = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_TXT;
      end
      S_TXT: begin
        if (slot_free) begin
          ov_nxt  = 1'b1;
          ob_nxt  = rd_data_r;
          ol_nxt  = 1'b0;
          sum_nxt = sum_r ^ rd_data_r;
          if (gcf_pkg::kept_t'(gcf_pkg::kept_t'(txt_i_r) + gcf_pkg::kept_t'(1)) == len_r) begin
            state_nxt = S_STAR;
          end else begin
            txt_i_nxt = txt_i_r + gcf_pkg::addr_t'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_STAR: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = gcf_pkg::CH_STAR;
          ol_nxt    = 1'b0;
          ck_nxt    = gcf_pkg::ck_digits(sum_r);
          ck_i_nxt  = gcf_pkg::ck_top(sum_r);
          state_nxt = S_CK;
        end
      end
      S_CK: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          ob_nxt = ck_byte;
          ol_nxt = 1'b0;
          if (ck_i_r == 2'd0) begin
            state_nxt = S_LF;
          end else begin
            ck_i_nxt = ck_i_r - 2'd1;
          end
        end
      end
      S_LF: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = gcf_pkg::CH_LF;
          ol_nxt    = 1'b1;
          lnum_nxt  = (lnum_r == gcf_pkg::LNUM_WRAP) ? '0 : gcf_pkg::bcd_inc(lnum_r);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kept_r  <= '0;
      trim_r  <= '0;
      cmt_r   <= 1'b0;
      lnum_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kept_r  <= kept_nxt;
      trim_r  <= trim_nxt;
      cmt_r   <= cmt_nxt;
      lnum_r  <= lnum_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r   <= len_nxt;
    dig_i_r <= dig_i_nxt;
    txt_i_r <= txt_i_nxt;
    sum_r   <= sum_nxt;
    ck_r    <= ck_nxt;
    ck_i_r  <= ck_i_nxt;
    ob_r    <= ob_nxt;
    ol_r    <= ol_nxt;
  end

`ifndef SYNTHESIS
  a_kept_cap: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= gcf_pkg::CAP_K)
    else $error("kept count beyond line capacity");

  a_trim_le_kept: assert property (@(posedge clk) disable iff (!rst_n)
    trim_r <= kept_r)
    else $error("trimmed length beyond kept count");

  a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.last) |-> (out_res.out_byte == gcf_pkg::CH_LF))
    else $error("last flag on a byte other than line feed");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (gcf_pkg::kept_t'(txt_i_r) < len_r))
    else $error("text read beyond framed length");

  a_no_write_framing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> ($stable(kept_r) || (kept_r == '0)))
    else $error("line memory fill moved while framing");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the g-code line framer: text bytes go in under
// random pacing, every framed line is predicted in a scoreboard and each
// output byte is compared with the oldest predicted byte
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  class line_frame_predictor;
    typedef struct packed {
      gcf_pkg::byte_t data;
      logic           eol;
    } frame_byte_t;

    gcf_pkg::byte_t text [gcf_pkg::LINE_CAP];
    int unsigned    kept;
    bit             skipping;
    bit [31:0]      line_no;
    frame_byte_t    framed_q[$];
    int unsigned    errors;

    function void push(gcf_pkg::byte_t b, logic eol);
      frame_byte_t fb;
      fb.data = b;
      fb.eol  = eol;
      framed_q.push_back(fb);
    endfunction

    function void frame_line();
      int unsigned    len;
      gcf_pkg::byte_t ck;
      gcf_pkg::byte_t digs[$];
      bit [31:0]      v;
      len  = kept;
      kept = 0;
      while (len > 0 && text[len-1] == gcf_pkg::CH_SPACE) len--;
      if (len == 0) return;
      v = line_no;
      do begin
        digs.push_front(gcf_pkg::byte_t'(gcf_pkg::CH_ZERO + v % 10));
        v = v / 10;
      end while (v != 0);
      push(gcf_pkg::CH_N, 1'b0);
      ck = gcf_pkg::CH_N;
      foreach (digs[i]) begin
        push(digs[i], 1'b0);
        ck ^= digs[i];
      end
      push(gcf_pkg::CH_SPACE, 1'b0);
      ck ^= gcf_pkg::CH_SPACE;
      for (int i = 0; i < len; i++) begin
        push(text[i], 1'b0);
        ck ^= text[i];
      end
      push(gcf_pkg::CH_STAR, 1'b0);
      if (ck >= 100) begin
        push(gcf_pkg::byte_t'(gcf_pkg::CH_ZERO + ck / 100), 1'b0);
        push(gcf_pkg::byte_t'(gcf_pkg::CH_ZERO + (ck / 10) % 10), 1'b0);
      end else if (ck >= 10) begin
        push(gcf_pkg::byte_t'(gcf_pkg::CH_ZERO + ck / 10), 1'b0);
      end
      push(gcf_pkg::byte_t'(gcf_pkg::CH_ZERO + ck % 10), 1'b0);
      push(gcf_pkg::CH_LF, 1'b1);
      line_no++;
    endfunction

    function void note_byte(gcf_pkg::byte_t b);
      if (b == gcf_pkg::CH_LF || b == gcf_pkg::CH_CR) begin
        frame_line();
        skipping = 1'b0;
      end else if (kept >= gcf_pkg::LINE_CAP) begin
        frame_line();
        skipping = 1'b1;
      end else begin
        if (b == gcf_pkg::CH_SEMI) skipping = 1'b1;
        if (!skipping) begin
          text[kept] = b;
          kept++;
        end
      end
    endfunction

    function void check_byte(gcf_pkg::byte_t b, logic eol);
      frame_byte_t want;
      if (framed_q.size() == 0) begin
        $display("%0t: unexpected output byte %h last %b", $time, b, eol);
        errors++;
        return;
      end
      want = framed_q.pop_front();
      if (b !== want.data) begin
        $display("%0t: out_byte expected %h actual %h", $time, want.data, b);
        errors++;
      end
      if (eol !== want.eol) begin
        $display("%0t: last expected %b actual %b", $time, want.eol, eol);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return framed_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  gcf_in_if  in_req();
  gcf_out_if out_res();

  gcode_line_number_checksum_framer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  line_frame_predictor frame_pred = new;
  int unsigned         bytes_sent;
  int unsigned         bytes_seen;
  bit                  tx_idle;
  bit                  rx_idle;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic int unsigned tx_gap();
    return tx_idle ? $urandom_range(0, 16) : 0;
  endfunction

  function automatic gcf_pkg::byte_t gcode_char();
    case ($urandom_range(0, 5))
      0, 1: return gcf_pkg::byte_t'(8'd65 + $urandom_range(0, 25));
      2, 3: return gcf_pkg::byte_t'(gcf_pkg::CH_ZERO + $urandom_range(0, 9));
      4: return gcf_pkg::CH_SPACE;
      default: return ($urandom_range(0, 1) != 0) ? 8'd46 : gcf_pkg::CH_STAR;
    endcase
  endfunction

  task automatic send_byte(input gcf_pkg::byte_t b, input int unsigned gap);
    @(negedge clk);
    if (gap != 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.valid   <= 1'b1;
    in_req.byte_in <= b;
    do @(posedge clk); while (!in_req.ready);
    frame_pred.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(gcf_pkg::byte_t'(s[i]), tx_gap());
  endtask

  task automatic send_random_line();
    gcf_pkg::byte_t q[$];
    int unsigned    n;
    int unsigned    kind;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      n = $urandom_range(1, 20);
      repeat (n) q.push_back(gcode_char());
      if ($urandom_range(0, 2) == 0) begin
        q.push_back(gcf_pkg::CH_SEMI);
        repeat ($urandom_range(0, 8)) q.push_back(gcode_char());
      end
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) q.push_back(gcf_pkg::CH_SPACE);
      end
    end else if (kind == 6) begin
      n = $urandom_range(38, 46);
      repeat (n) q.push_back(gcode_char());
      if (n > 40 && $urandom_range(0, 2) == 0) q[40] = gcf_pkg::CH_SEMI;
    end else if (kind == 7) begin
      repeat ($urandom_range(0, 4)) q.push_back(gcf_pkg::CH_SPACE);
      if ($urandom_range(0, 1) != 0) begin
        q.push_back(gcf_pkg::CH_SEMI);
        repeat ($urandom_range(0, 6)) q.push_back(gcode_char());
      end
    end else begin
      n = $urandom_range(1, 12);
      repeat (n) q.push_back(gcf_pkg::byte_t'($urandom_range(0, 255)));
    end
    if (kind != 9) begin
      case ($urandom_range(0, 3))
        0: q.push_back(gcf_pkg::CH_CR);
        1: begin
          q.push_back(gcf_pkg::CH_CR);
          q.push_back(gcf_pkg::CH_LF);
        end
        default: q.push_back(gcf_pkg::CH_LF);
      endcase
    end
    foreach (q[i]) send_byte(q[i], tx_gap());
  endtask

  task automatic take_byte(input int unsigned stall);
    @(negedge clk);
    if (stall != 0) begin
      out_res.ready <= 1'b0;
      repeat (stall) @(negedge clk);
    end
    out_res.ready <= 1'b1;
    do @(posedge clk); while (!out_res.valid);
    frame_pred.check_byte(out_res.out_byte, out_res.last);
    bytes_seen++;
  endtask

  initial begin
    out_res.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_idle = !rx_idle;
      // long hold so the framer backs up and stalls its input
      if (bytes_seen == 60) take_byte(400);
      else take_byte(rx_idle ? $urandom_range(0, 16) : 0);
    end
  end

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    in_req.valid   = 1'b0;
    in_req.byte_in = '0;
    rst_n          = 1'b0;
    tx_idle        = 1'b0;
    rx_idle        = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_text("G1 X0*\r\n");
    send_text("  \n");
    send_text(";c\n");
    send_text("M1 ;x\n");
    send_byte(8'h00, tx_gap());
    send_byte(8'hff, tx_gap());
    send_byte(8'h80, tx_gap());
    send_byte(gcf_pkg::CH_LF, tx_gap());

    while (bytes_sent < 370) begin
      tx_idle = ($urandom_range(0, 2) != 0);
      send_random_line();
    end
    @(negedge clk);
    in_req.valid <= 1'b0;

    while (frame_pred.pending() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (frame_pred.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== gcode_line_number_checksum_framer.f =====
sv/gcf_pkg.sv
sv/gcf_if.sv
sv/gcode_line_number_checksum_framer.sv
tb/sv/testbench.sv
